// File: rtl/sdf_pkg.sv
// Shared constants and register codes for the spring-damper force unit.
package sdf_pkg;

   // Widths of the configuration port.
   localparam int REG_W = 16;
   localparam int IDX_W = 2;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_REST_LENGTH = 2'd0;
   localparam logic [IDX_W-1:0] REG_STIFFNESS   = 2'd1;
   localparam logic [IDX_W-1:0] REG_DAMPING     = 2'd2;

   // Register reset values (unsigned; rest length in position units, stiffness and damping Q8.8).
   localparam logic [REG_W-1:0] REST_LENGTH_RESET = 16'd256;
   localparam logic [REG_W-1:0] STIFFNESS_RESET   = 16'd256;
   localparam logic [REG_W-1:0] DAMPING_RESET     = 16'd0;

   // Width of one packed vector field.
   localparam int FIELD_W = 48;

   // Unit vector: components carry 16 fraction bits and have magnitude up to 1.0.
   localparam int UNIT_SHIFT = 16;
   localparam int QUOT_W     = 17;
   localparam int U_W        = 18;

   // Scaling of the damping term and of the final component product.
   localparam int DAMP_SHIFT = 16;
   localparam int OUT_SHIFT  = 24;

   // Reported length field.
   localparam int               LEN_W   = 17;
   localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;

endpackage

// File: rtl/sdf_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
module sdf_sqrt #(
   parameter int IN_W   = 34,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     in_radicand,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int OUT_W = IN_W / 2;

   logic [IN_W-1:0]   rem_ff   [OUT_W];
   logic [IN_W-1:0]   root_ff  [OUT_W];
   logic [SIDE_W-1:0] side_ff  [OUT_W];
   logic              valid_ff [OUT_W];

   for (genvar s = 0; s < OUT_W; s++) begin : g_stage
      localparam int K = OUT_W - 1 - s;

      logic [IN_W-1:0]   rem_cur;
      logic [IN_W-1:0]   root_cur;
      logic [SIDE_W-1:0] side_cur;
      logic              valid_cur;
      logic [IN_W-1:0]   test;

      if (s == 0) begin : g_first
         assign rem_cur   = in_radicand;
         assign root_cur  = '0;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[s-1];
         assign root_cur  = root_ff[s-1];
         assign side_cur  = side_ff[s-1];
         assign valid_cur = valid_ff[s-1];
      end

      // Growth of the square when bit K is set in the root.
      assign test = (root_cur << (K + 1)) + (IN_W'(1) << (2 * K));

      // Keep the bit when the remainder still covers the growth.
      always_ff @(posedge clock) begin
         if (enable) begin
            if (rem_cur >= test) begin
               rem_ff[s]  <= rem_cur - test;
               root_ff[s] <= root_cur | (IN_W'(1) << K);
            end else begin
               rem_ff[s]  <= rem_cur;
               root_ff[s] <= root_cur;
            end
            side_ff[s] <= side_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_cur;
         end
      end
   end

   assign out_valid = valid_ff[OUT_W-1];
   assign out_root  = root_ff[OUT_W-1][OUT_W-1:0];
   assign out_side  = side_ff[OUT_W-1];

endmodule

// File: rtl/sdf_div.sv
// Pipelined restoring divider, several lanes over one shared divisor, one quotient bit a stage.
module sdf_div #(
   parameter int LANES  = 3,
   parameter int NUM_W  = 33,
   parameter int DEN_W  = 17,
   parameter int Q_W    = 17,
   parameter int SIDE_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [LANES*NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0]       in_den,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [LANES*Q_W-1:0]   out_quot,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int T_W = DEN_W + Q_W;

   logic [LANES-1:0][T_W-1:0] rem_ff   [Q_W];
   logic [LANES-1:0][Q_W-1:0] quot_ff  [Q_W];
   logic [DEN_W-1:0]          den_ff   [Q_W];
   logic [SIDE_W-1:0]         side_ff  [Q_W];
   logic                      valid_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int K = Q_W - 1 - s;

      logic [LANES-1:0][T_W-1:0] rem_cur;
      logic [LANES-1:0][Q_W-1:0] quot_cur;
      logic [DEN_W-1:0]          den_cur;
      logic [SIDE_W-1:0]         side_cur;
      logic                      valid_cur;
      logic [T_W-1:0]            test;

      if (s == 0) begin : g_first
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_cur[l]  = T_W'(in_num[l*NUM_W +: NUM_W]);
            assign quot_cur[l] = '0;
         end
         assign den_cur   = in_den;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[s-1];
         assign quot_cur  = quot_ff[s-1];
         assign den_cur   = den_ff[s-1];
         assign side_cur  = side_ff[s-1];
         assign valid_cur = valid_ff[s-1];
      end

      assign test = T_W'(den_cur) << K;

      // Subtract the shifted divisor in every lane where it fits.
      always_ff @(posedge clock) begin
         if (enable) begin
            for (int l = 0; l < LANES; l++) begin
               if (rem_cur[l] >= test) begin
                  rem_ff[s][l]  <= rem_cur[l] - test;
                  quot_ff[s][l] <= quot_cur[l] | (Q_W'(1) << K);
               end else begin
                  rem_ff[s][l]  <= rem_cur[l];
                  quot_ff[s][l] <= quot_cur[l];
               end
            end
            den_ff[s]  <= den_cur;
            side_ff[s] <= side_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_cur;
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quot[l*Q_W +: Q_W] = quot_ff[Q_W-1][l];
   end
   assign out_valid = valid_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// File: rtl/sdf_fifo.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
module sdf_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   output logic             full
);

   logic [WIDTH-1:0] mem [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem[rd_ptr_ff];
   assign full      = count_ff[1];

endmodule

// File: rtl/spring_damper_force_unit.sv
// Top level of the spring-damper force unit.
// Evaluates a damped spring between two bodies: separation length by a pipelined square root,
// unit direction by a pipelined divider, then the Hooke force with damping along the axis.
// One item is accepted every cycle while the result side keeps up; an input transfer passes
// to its result through the square root (one stage per root bit) and the divider (one stage
// per quotient bit), between the registered datapath stages. Results leave through a two-entry
// buffer, so req_tready only drops once two results are waiting on the result channel.
// Configuration writes are always taken and must only be issued while the unit is idle.
module spring_damper_force_unit #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input item.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // position_a, position_b, velocity_a, velocity_b.
   input  logic [191:0]               req_tdata,
   // fixed_a, fixed_b.
   input  logic [1:0]                 req_tuser,
   // Result item.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // force_a, force_b, current_length, zero fill.
   output logic [119:0]               rsp_tdata,
   // apply_a, apply_b.
   output logic [1:0]                 rsp_tuser,
   // Configuration writes.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sdf_pkg::IDX_W-1:0]  csr_index,
   input  logic [sdf_pkg::REG_W-1:0]  csr_data
);

   localparam int C      = COMPONENT_BITS;
   localparam int FW     = sdf_pkg::FIELD_W;
   localparam int PACK_W = 3 * C;
   localparam int D_W    = C + 1;
   localparam int SQ_W   = 2 * D_W;
   localparam int NUM_W  = D_W + sdf_pkg::UNIT_SHIFT;
   localparam int Q_W    = sdf_pkg::QUOT_W;
   localparam int U_W    = sdf_pkg::U_W;
   localparam int PROD_W = D_W + U_W;
   localparam int P_W    = PROD_W + 2;
   localparam int DIFF_W = ((D_W > sdf_pkg::REG_W) ? D_W : sdf_pkg::REG_W) + 1;
   localparam int S_W    = DIFF_W + sdf_pkg::REG_W + 1;
   localparam int PD_W   = P_W + sdf_pkg::REG_W + 1;
   localparam int DMP_W  = PD_W - sdf_pkg::DAMP_SHIFT;
   localparam int F_W    = ((DMP_W > S_W) ? DMP_W : S_W) + 1;
   localparam int M_W    = U_W + F_W;
   localparam int X_W    = M_W - sdf_pkg::OUT_SHIFT;
   localparam int LW     = (D_W > sdf_pkg::LEN_W) ? D_W : sdf_pkg::LEN_W;
   localparam int SQ_SIDE_W  = 6 * D_W + 2;
   localparam int DIV_SIDE_W = 3 * D_W + D_W + 5;
   localparam int BUF_W  = 2 * FW + 2 + sdf_pkg::LEN_W;

   localparam logic signed [X_W-1:0] SAT_HI = X_W'((64'sd1 <<< (C - 1)) - 64'sd1);
   localparam logic signed [X_W-1:0] SAT_LO = -SAT_HI - X_W'(1);
   localparam logic signed [C-1:0]   C_MIN  = {1'b1, {(C - 1){1'b0}}};
   localparam logic signed [C-1:0]   C_MAX  = {1'b0, {(C - 1){1'b1}}};

   // ---------------------------------------------------------------- configuration
   logic [sdf_pkg::REG_W-1:0] rest_length_ff;
   logic [sdf_pkg::REG_W-1:0] stiffness_ff;
   logic [sdf_pkg::REG_W-1:0] damping_ff;

   assign csr_ready = 1'b1;

   // Register writes; an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_length_ff <= sdf_pkg::REST_LENGTH_RESET;
         stiffness_ff   <= sdf_pkg::STIFFNESS_RESET;
         damping_ff     <= sdf_pkg::DAMPING_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sdf_pkg::REG_REST_LENGTH: rest_length_ff <= csr_data;
            sdf_pkg::REG_STIFFNESS:   stiffness_ff   <= csr_data;
            sdf_pkg::REG_DAMPING:     damping_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   logic advance;
   logic buf_full;

   assign advance    = !buf_full;
   assign req_tready = advance;

   // ---------------------------------------------------------------- stage 1: differences
   logic [PACK_W-1:0] pos_a, pos_b, vel_a, vel_b;
   logic [2:0][D_W-1:0] d_in, dv_in;

   assign pos_a = PACK_W'(req_tdata[0*FW +: FW]);
   assign pos_b = PACK_W'(req_tdata[1*FW +: FW]);
   assign vel_a = PACK_W'(req_tdata[2*FW +: FW]);
   assign vel_b = PACK_W'(req_tdata[3*FW +: FW]);

   for (genvar i = 0; i < 3; i++) begin : g_diff
      assign d_in[i]  = D_W'($signed(pos_b[i*C +: C])) - D_W'($signed(pos_a[i*C +: C]));
      assign dv_in[i] = D_W'($signed(vel_b[i*C +: C])) - D_W'($signed(vel_a[i*C +: C]));
   end

   logic                v1_ff;
   logic [2:0][D_W-1:0] d1_ff, dv1_ff;
   logic [1:0]          fix1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff   <= d_in;
         dv1_ff  <= dv_in;
         fix1_ff <= req_tuser;
      end
   end

   // ---------------------------------------------------------------- stage 2: squares
   logic                v2_ff;
   logic [2:0][SQ_W-1:0] sq2_ff;
   logic [2:0][D_W-1:0] d2_ff, dv2_ff;
   logic [1:0]          fix2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= SQ_W'($signed(d1_ff[i]) * $signed(d1_ff[i]));
         end
         d2_ff   <= d1_ff;
         dv2_ff  <= dv1_ff;
         fix2_ff <= fix1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: squared length
   logic                v3_ff;
   logic [SQ_W-1:0]     len2_ff;
   logic [2:0][D_W-1:0] d3_ff, dv3_ff;
   logic [1:0]          fix3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         len2_ff <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         d3_ff   <= d2_ff;
         dv3_ff  <= dv2_ff;
         fix3_ff <= fix2_ff;
      end
   end

   // ---------------------------------------------------------------- square root
   logic                 sq_valid;
   logic [D_W-1:0]       sq_len;
   logic [SQ_SIDE_W-1:0] sq_side;
   logic [2:0][D_W-1:0]  sq_d, sq_dv;
   logic [1:0]           sq_fix;

   sdf_sqrt #(
      .IN_W   (SQ_W),
      .SIDE_W (SQ_SIDE_W)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (v3_ff),
      .in_radicand (len2_ff),
      .in_side     ({fix3_ff, dv3_ff, d3_ff}),
      .out_valid   (sq_valid),
      .out_root    (sq_len),
      .out_side    (sq_side)
   );

   assign {sq_fix, sq_dv, sq_d} = sq_side;

   // ---------------------------------------------------------------- unit direction
   logic [3*NUM_W-1:0]    div_num;
   logic [2:0]            d_sign;
   logic                  dv_valid;
   logic [3*Q_W-1:0]      dv_quot;
   logic [DIV_SIDE_W-1:0] dv_side;
   logic [2:0][D_W-1:0]   dq_dv;
   logic [D_W-1:0]        dq_len;
   logic [2:0]            dq_sign;
   logic [1:0]            dq_fix;

   // Magnitudes scaled by 2^16 are divided; signs travel alongside.
   for (genvar i = 0; i < 3; i++) begin : g_num
      logic [D_W-1:0] mag;
      assign d_sign[i] = sq_d[i][D_W-1];
      assign mag       = d_sign[i] ? (D_W'(0) - sq_d[i]) : sq_d[i];
      assign div_num[i*NUM_W +: NUM_W] = {mag, {sdf_pkg::UNIT_SHIFT{1'b0}}};
   end

   sdf_div #(
      .LANES  (3),
      .NUM_W  (NUM_W),
      .DEN_W  (D_W),
      .Q_W    (Q_W),
      .SIDE_W (DIV_SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (sq_valid),
      .in_num    (div_num),
      .in_den    (sq_len),
      .in_side   ({sq_fix, d_sign, sq_dv, sq_len}),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   assign {dq_fix, dq_sign, dq_dv, dq_len} = dv_side;

   // ---------------------------------------------------------------- stage 4: signed unit vector
   logic                       v4_ff;
   logic signed [U_W-1:0]      u4_ff [3];
   logic [2:0][D_W-1:0]        dv4_ff;
   logic [D_W-1:0]             len4_ff;
   logic [1:0]                 fix4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            if (dq_sign[i]) begin
               u4_ff[i] <= U_W'(0) - U_W'(dv_quot[i*Q_W +: Q_W]);
            end else begin
               u4_ff[i] <= U_W'(dv_quot[i*Q_W +: Q_W]);
            end
         end
         dv4_ff  <= dq_dv;
         len4_ff <= dq_len;
         fix4_ff <= dq_fix;
      end
   end

   // ---------------------------------------------------------------- stage 5: products
   logic                        v5_ff;
   logic signed [PROD_W-1:0]    prod5_ff [3];
   logic signed [S_W-1:0]       s5_ff;
   logic signed [U_W-1:0]       u5_ff [3];
   logic [D_W-1:0]              len5_ff;
   logic [1:0]                  fix5_ff;
   logic signed [DIFF_W-1:0]    stretch;

   assign stretch = $signed(DIFF_W'(len4_ff)) - $signed(DIFF_W'(rest_length_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            prod5_ff[i] <= $signed(dv4_ff[i]) * u4_ff[i];
         end
         s5_ff   <= stretch * $signed({1'b0, stiffness_ff});
         u5_ff   <= u4_ff;
         len5_ff <= len4_ff;
         fix5_ff <= fix4_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6: projection sum
   logic                     v6_ff;
   logic signed [P_W-1:0]    p6_ff;
   logic signed [S_W-1:0]    s6_ff;
   logic signed [U_W-1:0]    u6_ff [3];
   logic [D_W-1:0]           len6_ff;
   logic [1:0]               fix6_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p6_ff   <= P_W'(prod5_ff[0]) + P_W'(prod5_ff[1]) + P_W'(prod5_ff[2]);
         s6_ff   <= s5_ff;
         u6_ff   <= u5_ff;
         len6_ff <= len5_ff;
         fix6_ff <= fix5_ff;
      end
   end

   // ---------------------------------------------------------------- stage 7: damping product
   logic                     v7_ff;
   logic signed [PD_W-1:0]   pd7_ff;
   logic signed [S_W-1:0]    s7_ff;
   logic signed [U_W-1:0]    u7_ff [3];
   logic [D_W-1:0]           len7_ff;
   logic [1:0]               fix7_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pd7_ff  <= p6_ff * $signed({1'b0, damping_ff});
         s7_ff   <= s6_ff;
         u7_ff   <= u6_ff;
         len7_ff <= len6_ff;
         fix7_ff <= fix6_ff;
      end
   end

   // ---------------------------------------------------------------- stage 8: scalar force
   // The scalar force register is one bit wider than its wider term, so no clamp is needed.
   logic                     v8_ff;
   logic signed [F_W-1:0]    f8_ff;
   logic signed [U_W-1:0]    u8_ff [3];
   logic [D_W-1:0]           len8_ff;
   logic [1:0]               fix8_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         f8_ff   <= F_W'(s7_ff) - F_W'(pd7_ff >>> sdf_pkg::DAMP_SHIFT);
         u8_ff   <= u7_ff;
         len8_ff <= len7_ff;
         fix8_ff <= fix7_ff;
      end
   end

   // ---------------------------------------------------------------- stage 9: force components
   logic                     v9_ff;
   logic signed [M_W-1:0]    m9_ff [3];
   logic [D_W-1:0]           len9_ff;
   logic [1:0]               fix9_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            m9_ff[i] <= u8_ff[i] * f8_ff;
         end
         len9_ff <= len8_ff;
         fix9_ff <= fix8_ff;
      end
   end

   // Valid bits of the datapath stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= dv_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   // ---------------------------------------------------------------- saturation and packing
   logic              nonzero;
   logic [PACK_W-1:0] force_a_pack, force_b_pack;
   logic [LW-1:0]     len_wide;
   logic [sdf_pkg::LEN_W-1:0] len_sat;
   logic              apply_a, apply_b;

   assign nonzero = (len9_ff != '0);

   for (genvar i = 0; i < 3; i++) begin : g_sat
      logic signed [X_W-1:0] x;
      logic signed [C-1:0]   c;
      logic signed [C-1:0]   n;

      assign x = $signed(m9_ff[i][M_W-1:sdf_pkg::OUT_SHIFT]);

      always_comb begin
         if (x > SAT_HI) begin
            c = C_MAX;
         end else if (x < SAT_LO) begin
            c = C_MIN;
         end else begin
            c = x[C-1:0];
         end
         // The most negative value has no positive counterpart and saturates.
         if (c == C_MIN) begin
            n = C_MAX;
         end else begin
            n = -c;
         end
      end

      assign force_a_pack[i*C +: C] = nonzero ? c : '0;
      assign force_b_pack[i*C +: C] = nonzero ? n : '0;
   end

   assign len_wide = LW'(len9_ff);
   assign len_sat  = (len_wide > LW'(sdf_pkg::LEN_MAX)) ? sdf_pkg::LEN_MAX
                                                       : len_wide[sdf_pkg::LEN_W-1:0];
   assign apply_a  = nonzero && !fix9_ff[0];
   assign apply_b  = nonzero && !fix9_ff[1];

   // ---------------------------------------------------------------- output buffer
   logic             buf_push;
   logic             buf_pop;
   logic [BUF_W-1:0] buf_out;

   assign buf_push = advance && v9_ff;
   assign buf_pop  = rsp_tvalid && rsp_tready;

   sdf_fifo #(
      .WIDTH (BUF_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (buf_push),
      .push_data ({apply_b, apply_a, len_sat, FW'(force_b_pack), FW'(force_a_pack)}),
      .pop       (buf_pop),
      .out_valid (rsp_tvalid),
      .out_data  (buf_out),
      .full      (buf_full)
   );

   assign rsp_tdata = {7'd0, buf_out[2*FW + sdf_pkg::LEN_W - 1:0]};
   assign rsp_tuser = buf_out[BUF_W-1:BUF_W-2];

endmodule
